// File: hw/rtl/srp_pkg.sv
// Shared constants, types and state codes for the shelf rectangle packer.
// Used by srp_ctrl, srp_dpath and shelf_rect_packer. No dependencies.
package srp_pkg;
    localparam int MAX_RECTS = 64;
    localparam int IDX_W = $clog2(MAX_RECTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SZ_W = 13;
    localparam logic [SZ_W-1:0] SIZE_CAP = 13'd4096;

    localparam logic [0:0] REG_MARGIN = 1'd0;
    localparam logic [0:0] REG_LIMIT = 1'd1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_RD = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;
    localparam logic [2:0] ST_CMP = 3'd5;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;     // store the request's rectangle
        logic init;     // clear run state, reset sort and place counters
        logic sort_rd;  // read the two neighbors for the next comparison
        logic sort_stp; // one comparison step of the insertion sort
        logic rd;       // fetch the next rectangle in sorted order
        logic place;    // place the fetched rectangle
        logic rpt;      // restart the report index at entry zero
        logic emit;     // present one result
    } t_cmd;

    typedef struct packed {
        logic full;
        logic sort_done;
        logic place_done;
        logic out_done;
    } t_stat;

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v);
        logic [SZ_W-1:0] r;
        r = v;
        if (v == '0) r = SZ_W'(1);
        else if (v > SIZE_CAP) r = SIZE_CAP;
        return r;
    endfunction
endpackage

// File: hw/rtl/srp_ctrl.sv
// Sequencer for the shelf rectangle packer: load, sort, place, report.
// Depends on srp_pkg.
module srp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_last_rect,
    input  srp_pkg::t_stat  i_stat,
    output srp_pkg::t_cmd   o_cmd,
    output logic            busy
);
    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= srp_pkg::ST_LOAD;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            srp_pkg::ST_LOAD: begin
                if (start) begin
                    o_cmd.load = !i_stat.full;
                    if (i_last_rect) begin
                        o_cmd.init = 1'b1;
                        n_state = srp_pkg::ST_SORT;
                    end
                end
            end
            srp_pkg::ST_SORT: begin
                if (i_stat.sort_done) n_state = srp_pkg::ST_RD;
                else begin
                    o_cmd.sort_rd = 1'b1;
                    n_state = srp_pkg::ST_CMP;
                end
            end
            srp_pkg::ST_CMP: begin
                o_cmd.sort_stp = 1'b1;
                n_state = srp_pkg::ST_SORT;
            end
            srp_pkg::ST_RD: begin
                if (i_stat.place_done) begin
                    o_cmd.rpt = 1'b1;
                    n_state = srp_pkg::ST_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = srp_pkg::ST_PLACE;
                end
            end
            srp_pkg::ST_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = srp_pkg::ST_RD;
            end
            srp_pkg::ST_OUT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.out_done) n_state = srp_pkg::ST_LOAD;
            end
            default: n_state = srp_pkg::ST_LOAD;
        endcase
    end

    assign busy = (r_state != srp_pkg::ST_LOAD);
endmodule

// File: hw/rtl/srp_dpath.sv
// Datapath for the shelf rectangle packer: rectangle stores, insertion sort,
// row placement and result registers. Depends on srp_pkg.
module srp_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  srp_pkg::t_cmd            i_cmd,
    input  logic [3:0]               i_margin,
    input  logic [12:0]              i_size_limit,
    input  logic [12:0]              i_rect_width,
    input  logic [12:0]              i_rect_height,
    output srp_pkg::t_stat           o_stat,
    output logic                     o_valid,
    output logic [5:0]               o_cell_index,
    output logic [11:0]              o_pos_x,
    output logic [12:0]              o_pos_y,
    output logic                     o_placed,
    output logic [12:0]              o_atlas_width,
    output logic [13:0]              o_atlas_height,
    output logic                     o_last_result
);
    localparam int IW = srp_pkg::IDX_W;
    localparam int CW = srp_pkg::CNT_W;
    localparam int N = srp_pkg::MAX_RECTS;

    // Each slot holds a whole record (width, height, arrival index), and the
    // sort moves records between slots. A comparison registers two neighboring
    // slots, then swaps them in the next cycle if they are out of order.
    logic [12:0]   r_wid [N];
    logic [12:0]   r_hgt [N];
    logic [IW-1:0] r_ord [N];
    logic [11:0]   r_xs  [N];
    logic [12:0]   r_ys  [N];
    logic [N-1:0]  r_pmark;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i, r_j;   // sort: outer index and current insert position
    logic [CW-1:0] r_k;        // place/report index
    logic          r_stop;
    logic [13:0]   r_cur_x, r_row_org;
    logic [12:0]   r_row_h, r_widest;
    logic [IW-1:0] r_id, r_id_b;
    logic [12:0]   r_w, r_h, r_w_b, r_h_b;

    logic [CW-1:0] load_cnt;
    logic [IW-1:0] jm1, jidx, rd_a;
    logic          swap;
    logic [12:0]   lim;
    logic [14:0]   gap, cx_g, fit, org_n;

    assign load_cnt = i_cmd.load ? r_cnt + CW'(1) : r_cnt;
    assign jidx = r_j[IW-1:0];
    assign jm1 = IW'(r_j - CW'(1));
    assign rd_a = i_cmd.rd ? r_k[IW-1:0] : jm1;
    assign swap = (r_j != '0) && (r_h < r_h_b);
    assign lim = (i_size_limit > srp_pkg::SIZE_CAP) ? srp_pkg::SIZE_CAP : i_size_limit;
    assign gap = 15'({i_margin, 1'b0});
    assign cx_g = (r_cur_x != '0) ? 15'(r_cur_x) + gap : 15'(r_cur_x);
    assign fit = cx_g + 15'(r_w);
    assign org_n = 15'(r_row_org) + 15'(r_row_h) + gap;

    assign o_stat.full = (r_cnt == CW'(N));
    assign o_stat.sort_done = (r_i >= r_cnt);
    assign o_stat.place_done = r_stop || (r_k >= r_cnt);
    assign o_stat.out_done = (r_k + CW'(1) >= r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wid[r_cnt[IW-1:0]] <= srp_pkg::clamp_size(i_rect_width);
            r_hgt[r_cnt[IW-1:0]] <= srp_pkg::clamp_size(i_rect_height);
            r_ord[r_cnt[IW-1:0]] <= r_cnt[IW-1:0];
        end else if (i_cmd.sort_stp && swap) begin
            r_wid[jm1] <= r_w_b;
            r_wid[jidx] <= r_w;
            r_hgt[jm1] <= r_h_b;
            r_hgt[jidx] <= r_h;
            r_ord[jm1] <= r_id_b;
            r_ord[jidx] <= r_id;
        end
        if (i_cmd.sort_rd || i_cmd.rd) begin
            r_id <= r_ord[rd_a];
            r_w <= r_wid[rd_a];
            r_h <= r_hgt[rd_a];
        end
        if (i_cmd.sort_rd) begin
            r_id_b <= r_ord[jidx];
            r_w_b <= r_wid[jidx];
            r_h_b <= r_hgt[jidx];
        end
        if (i_cmd.place && !(fit > 15'(lim) && org_n > 15'(lim))) begin
            r_xs[r_id] <= (fit > 15'(lim)) ? 12'd0 : cx_g[11:0];
            r_ys[r_id] <= (fit > 15'(lim)) ? org_n[12:0] : r_row_org[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_stop <= 1'b0;
            r_cur_x <= '0;
            r_row_org <= '0;
            r_row_h <= '0;
            r_widest <= '0;
            r_pmark <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            r_cnt <= load_cnt;
            if (i_cmd.init) begin
                r_i <= CW'(1);
                r_j <= CW'(1);
                r_k <= '0;
                r_stop <= 1'b0;
                r_cur_x <= '0;
                r_row_org <= '0;
                r_row_h <= '0;
                r_widest <= '0;
                r_pmark <= '0;
            end
            if (i_cmd.sort_stp) begin
                if (swap) r_j <= r_j - CW'(1);
                else begin
                    r_i <= r_i + CW'(1);
                    r_j <= r_i + CW'(1);
                end
            end
            if (i_cmd.place) begin
                if (fit > 15'(lim) && org_n > 15'(lim)) begin
                    r_stop <= 1'b1;
                    r_row_org <= org_n[13:0];
                end else begin
                    r_k <= r_k + CW'(1);
                    r_pmark[r_id] <= 1'b1;
                    if (fit > 15'(lim)) begin
                        r_row_org <= org_n[13:0];
                        r_cur_x <= 14'(r_w);
                        r_row_h <= r_h;
                        if (r_w > r_widest) r_widest <= r_w;
                    end else begin
                        r_cur_x <= fit[13:0];
                        if (r_h > r_row_h) r_row_h <= r_h;
                        if (fit > 15'(r_widest)) r_widest <= fit[12:0];
                    end
                end
            end
            if (i_cmd.rpt) r_k <= '0;
            if (i_cmd.emit) begin
                r_k <= r_k + CW'(1);
                if (o_stat.out_done) r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_cell_index <= r_k[IW-1:0];
            o_placed <= r_pmark[r_k[IW-1:0]];
            o_pos_x <= r_pmark[r_k[IW-1:0]] ? r_xs[r_k[IW-1:0]] : 12'd0;
            o_pos_y <= r_pmark[r_k[IW-1:0]] ? r_ys[r_k[IW-1:0]] : 13'd0;
            o_last_result <= o_stat.out_done;
            o_atlas_width <= o_stat.out_done ? r_widest : 13'd0;
            o_atlas_height <= o_stat.out_done ? 14'(r_row_org + 14'(r_row_h)) : 14'd0;
        end
    end
endmodule

// File: hw/rtl/shelf_rect_packer.sv
// Shelf rectangle packer top level: config registers, sequencer, datapath.
// Depends on srp_pkg, srp_ctrl and srp_dpath.
//
// Rectangles are loaded one per cycle while busy is low; the request with
// last_rect high starts packing. The insertion sort reads and then compares
// one neighboring pair per step, and a set of n rectangles needs n-1 steps
// plus one per out-of-order pair (at most n*(n-1)/2). Placement then fetches
// each rectangle and places it (single shared compare/add path), then the
// results follow, one result per cycle with no gaps, marked by o_valid.
// The receiver cannot stall; results must be taken as they appear.
module shelf_rect_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_wr_en,
    input  logic [0:0]  i_wr_index,
    input  logic [12:0] i_wr_data,
    input  logic [12:0] i_rect_width,
    input  logic [12:0] i_rect_height,
    input  logic        i_last_rect,
    output logic        o_valid,
    output logic [5:0]  o_cell_index,
    output logic [11:0] o_pos_x,
    output logic [12:0] o_pos_y,
    output logic        o_placed,
    output logic [12:0] o_atlas_width,
    output logic [13:0] o_atlas_height,
    output logic        o_last_result
);
    logic [3:0]     r_margin;
    logic [12:0]    r_size_limit;
    srp_pkg::t_cmd  cmd;
    srp_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= 4'd1;
            r_size_limit <= 13'd2048;
        end else if (i_wr_en) begin
            case (i_wr_index)
                srp_pkg::REG_MARGIN: r_margin <= i_wr_data[3:0];
                srp_pkg::REG_LIMIT:  r_size_limit <= i_wr_data;
                default: ;
            endcase
        end
    end

    srp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .i_last_rect(i_last_rect), .i_stat(stat), .o_cmd(cmd), .busy(busy)
    );

    srp_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_margin(r_margin), .i_size_limit(r_size_limit),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .o_stat(stat), .o_valid(o_valid), .o_cell_index(o_cell_index),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_placed(o_placed),
        .o_atlas_width(o_atlas_width), .o_atlas_height(o_atlas_height),
        .o_last_result(o_last_result)
    );
endmodule
